### sv/flb_pkg.sv
// Shared types and constants for the FIFO/LIFO word buffer.
package flb_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int OP_W     = 2;
    localparam int ITEM_W   = 32;
    localparam int COUNT_W  = 5;

    // Result tdata layout, lowest bit first
    localparam int POPPED_LSB  = 0;
    localparam int POP_OK_BIT  = 32;
    localparam int DROPPED_BIT = 33;
    localparam int COUNT_LSB   = 34;
    localparam int EMPTY_BIT   = 39;
    localparam int M_TDATA_W   = 40;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    // Per-transaction status handed from the pointer unit to the output stages
    typedef struct packed {
        logic               pop_ok;
        logic               push_dropped;
        logic [COUNT_W-1:0] count;
        logic               empty;
    } status_t;

endpackage

### sv/flb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module flb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/flb_ctrl.sv
// Head/count pointer unit: decodes one operation, drives RAM ports, reports status.
module flb_ctrl
    import flb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     accept,
    input  op_t                      op,
    input  logic                     lifo_mode,
    output logic                     ram_we,
    output logic [$clog2(DEPTH)-1:0] ram_waddr,
    output logic                     ram_re,
    output logic [$clog2(DEPTH)-1:0] ram_raddr,
    output status_t                  status
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    logic [PW-1:0] head_reg,  head_next;
    logic [CW-1:0] count_reg, count_next;

    logic [SW-1:0] tail_sum, last_sum, head_sum;
    logic [PW-1:0] tail_slot, last_slot, head_inc;
    logic          full, empty_now;
    logic          pop_ok, dropped;

    // head below DEPTH, offset at most DEPTH, so one conditional subtract wraps it
    assign tail_sum = SW'(head_reg) + SW'(count_reg);
    assign last_sum = tail_sum - SW'(1);
    assign head_sum = SW'(head_reg) + SW'(1);

    assign tail_slot = PW'((tail_sum >= SW'(DEPTH)) ? tail_sum - SW'(DEPTH) : tail_sum);
    assign last_slot = PW'((last_sum >= SW'(DEPTH)) ? last_sum - SW'(DEPTH) : last_sum);
    assign head_inc  = PW'((head_sum >= SW'(DEPTH)) ? head_sum - SW'(DEPTH) : head_sum);

    assign full      = (count_reg == CW'(DEPTH));
    assign empty_now = (count_reg == '0);

    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_raddr  = head_reg;
        pop_ok     = 1'b0;
        dropped    = 1'b0;
        unique case (op)
            OP_PUSH: begin
                if (full) begin
                    dropped = 1'b1;
                end else begin
                    ram_we     = accept;
                    count_next = count_reg + CW'(1);
                end
            end
            OP_POP: begin
                if (!empty_now) begin
                    ram_re     = accept;
                    pop_ok     = 1'b1;
                    count_next = count_reg - CW'(1);
                    if (lifo_mode) begin
                        ram_raddr = last_slot;
                    end else begin
                        head_next = head_inc;
                    end
                end
            end
            OP_CLEAR: begin
                head_next  = '0;
                count_next = '0;
            end
            OP_NOP: begin
            end
            default: begin
            end
        endcase
    end

    assign ram_waddr = tail_slot;

    assign status.pop_ok       = pop_ok;
    assign status.push_dropped = dropped;
    assign status.count        = COUNT_W'(count_next);
    assign status.empty        = (count_next == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else if (accept) begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

endmodule

### sv/fifo_lifo_buffer.sv
// Top level of the configurable FIFO/LIFO word buffer.
//
// Input channel (s_): one transaction per operation. s_tuser carries the
// operation code (push, pop, clear, no-op); s_tdata carries the word to push.
// Output channel (m_): exactly one result transaction per input transaction,
// in order: popped word, pop_ok, push_dropped, count after the operation and
// an empty flag.
// Config: cfg_wr_en/cfg_wr_data write lifo_mode (1 = stack, 0 = queue). Write
// it only while no transaction is in flight; it applies from the next pop.
// Timing: the accepting edge updates the pointers, reads the RAM and loads
// stage A; m_tvalid rises when stage A moves on into the output register,
// stage B, which a stalled output can hold back.
// Throughput: one transaction per cycle while the result channel does not stall;
// every operation touches the pointers and at most one RAM port, which is what sets that rate.
// Stall: two results can be held internally while m_tready is low; after that
// s_tready drops until the receiver takes one.
// Reset: pointers and count go to zero, mode goes to queue and both result
// stages empty. The word store is not cleared by reset.
module fifo_lifo_buffer
    import flb_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [ITEM_W-1:0]    s_tdata,   // [31:0] item_value
    input  logic [OP_W-1:0]      s_tuser,   // [1:0] operation
    // result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [31:0] popped_value, [32] pop_ok,
                                            // [33] push_dropped, [38:34] stored_count,
                                            // [39] is_empty
    // configuration
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data  // lifo_mode
);

    localparam int PW = $clog2(DEPTH);

    logic                  mode_reg;
    logic                  accept;

    // stage A: status waiting on the RAM read
    logic                  a_valid_reg;
    status_t               a_status_reg;
    logic                  a_advance;

    // stage B: output register
    logic                  b_valid_reg;
    logic [M_TDATA_W-1:0]  b_tdata_reg;
    logic [M_TDATA_W-1:0]  b_tdata_next;

    logic                  ram_we, ram_re;
    logic [PW-1:0]         ram_waddr, ram_raddr;
    logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;
    logic [63:0]           rd_wide;
    logic [ITEM_W-1:0]     popped;
    status_t               status;

    assign a_advance = a_valid_reg && (!b_valid_reg || m_tready);
    assign s_tready  = !a_valid_reg || a_advance;
    assign accept    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            mode_reg <= cfg_wr_data;
        end
    end

    flb_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .op        (op_t'(s_tuser)),
        .lifo_mode (mode_reg),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .status    (status)
    );

    assign ram_wdata = DATA_WIDTH'(s_tdata);

    flb_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // RAM data only moves on a successful pop accept, so it holds while A waits
    assign rd_wide = 64'(ram_rdata);
    assign popped  = a_status_reg.pop_ok ? rd_wide[ITEM_W-1:0] : '0;

    always_comb begin
        b_tdata_next                                 = '0;
        b_tdata_next[POPPED_LSB +: ITEM_W]           = popped;
        b_tdata_next[POP_OK_BIT]                     = a_status_reg.pop_ok;
        b_tdata_next[DROPPED_BIT]                    = a_status_reg.push_dropped;
        b_tdata_next[COUNT_LSB +: COUNT_W]           = a_status_reg.count;
        b_tdata_next[EMPTY_BIT]                      = a_status_reg.empty;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                a_valid_reg <= 1'b1;
            end else if (a_advance) begin
                a_valid_reg <= 1'b0;
            end
            if (a_advance) begin
                b_valid_reg <= 1'b1;
            end else if (m_tready) begin
                b_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            a_status_reg <= status;
        end
        if (a_advance) begin
            b_tdata_reg <= b_tdata_next;
        end
    end

    assign m_tvalid = b_valid_reg;
    assign m_tdata  = b_tdata_reg;

endmodule

### sv/flb_checker.sv
// Port-level checker for the FIFO/LIFO buffer, bound to the top level.
module flb_checker
    import flb_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // stalled result must not change
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a failed or absent pop reports a zero word
    a_zero_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[POP_OK_BIT] |-> m_tdata[POPPED_LSB +: ITEM_W] == '0)
        else $error("nonzero word without pop_ok");

    // one operation cannot both pop and drop a push
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[POP_OK_BIT] && m_tdata[DROPPED_BIT]))
        else $error("pop_ok and push_dropped together");

    // when empty or a push was dropped, the empty flag agrees with the count, and a dropped push means not empty
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[EMPTY_BIT] || m_tdata[DROPPED_BIT]) |->
            (m_tdata[EMPTY_BIT] == (m_tdata[COUNT_LSB +: COUNT_W] == '0))
            && !(m_tdata[EMPTY_BIT] && m_tdata[DROPPED_BIT]))
        else $error("empty flag inconsistent");

    // reset drains the output
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind fifo_lifo_buffer flb_checker u_flb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
